/* rtl/core/c_number_literal_scanner_unit_defines.svh */
// assertion macros for the numeric literal scanner checker
// expects clk and rst_n in the scope where a macro is used
`ifndef C_NUMBER_LITERAL_SCANNER_UNIT_DEFINES_SVH
`define C_NUMBER_LITERAL_SCANNER_UNIT_DEFINES_SVH

// checked only outside reset
`define CNLS_ASSERT_RUN(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cnls: run check failed");

// checked in the cycle after the antecedent, also across reset
`define CNLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cnls: next cycle check failed");

// next cycle check that is dropped while reset is active
`define CNLS_ASSERT_RUN_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cnls: stall check failed");

`endif

/* rtl/core/cnls_pkg.sv */
// shared types and constants of the numeric literal scanner
// no dependencies
`timescale 1ns / 1ps

package cnls_pkg;

  // result kinds
  localparam logic [1:0] KIND_INT   = 2'd0;
  localparam logic [1:0] KIND_FLOAT = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  // characters with a role of their own
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_E  = 8'h65;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_LC_Z  = 8'h7a;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_Z  = 8'h5a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  // decoded character classes
  typedef struct packed {
    logic digit;
    logic alpha;
    logic word;
    logic hex;
    logic zero;
    logic bin;
    logic lc_b;
    logic lc_x;
    logic lc_e;
    logic sign;
    logic dot;
  } char_class_t;

  // one step's result
  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [7:0] length;
  } scan_res_t;

endpackage

/* rtl/core/c_number_literal_scanner_unit.sv */
// channel   | dir | tvalid/tready            | tdata       | tuser/tlast
// ----------+-----+--------------------------+-------------+------------------
// in        | in  | in_tvalid / in_tready    | [7:0] ch    | tlast end_of_input
// out       | out | out_tvalid / out_tready  | [7:0] length| tuser [1:0] kind
//
// one beat per cycle sustained while the result register is not stalled;
// a beat passes the input register, then the result register, and its result is set by
// the single state update per character in cnls_fsm
// synchronous active low reset returns the scanner to idle with a zero count
// a stalled result register holds the input register, which holds in_tready low
// top level of the numeric literal scanner; depends on cnls_pkg, cnls_classify, cnls_fsm
`timescale 1ns / 1ps

module c_number_literal_scanner_unit #(
  parameter int unsigned MAX_LENGTH = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,   // end_of_input
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] length
  output logic [1:0] out_tuser   // [1:0] kind
);
  import cnls_pkg::*;

  logic       in_vld_r;
  logic [7:0] ch_r;
  logic       eoi_r;
  logic       out_vld_r;
  logic [7:0] len_r;
  logic [1:0] kind_r;

  logic        step_en;
  char_class_t cls;
  scan_res_t   res;

  // the held beat moves on whenever the result register can take it
  assign step_en   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step_en;

  cnls_classify u_classify (
    .ch  (ch_r),
    .cls (cls)
  );

  cnls_fsm #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .eoi     (eoi_r),
    .cls     (cls),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r  <= in_tdata;
      eoi_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_en && res.vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res.vld) begin
      len_r  <= res.length;
      kind_r <= res.kind;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = len_r;
  assign out_tuser  = kind_r;

endmodule

/* rtl/core/cnls_classify.sv */
// character class decoder of the numeric literal scanner
// depends on cnls_pkg
`timescale 1ns / 1ps

module cnls_classify (
  input  logic [7:0]           ch,
  output cnls_pkg::char_class_t cls
);
  import cnls_pkg::*;

  logic is_digit;
  logic is_lower;
  logic is_upper;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_lower = (ch >= CH_LC_A) && (ch <= CH_LC_Z);
  assign is_upper = (ch >= CH_UC_A) && (ch <= CH_UC_Z);

  always_comb begin
    cls.digit = is_digit;
    cls.alpha = is_lower || is_upper;
    cls.word  = is_digit || is_lower || is_upper || (ch == CH_UNDER);
    cls.hex   = is_digit || ((ch >= CH_LC_A) && (ch <= CH_LC_F)) ||
                ((ch >= CH_UC_A) && (ch <= CH_UC_F));
    cls.zero  = (ch == CH_ZERO);
    cls.bin   = (ch == CH_ZERO) || (ch == CH_ONE);
    cls.lc_b  = (ch == CH_LC_B);
    cls.lc_x  = (ch == CH_LC_X);
    cls.lc_e  = (ch == CH_LC_E);
    cls.sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    cls.dot   = (ch == CH_DOT);
  end

endmodule

/* rtl/core/cnls_fsm.sv */
// scan state machine: literal phase, character count and result decision
// depends on cnls_pkg
`timescale 1ns / 1ps

module cnls_fsm #(
  parameter int unsigned MAX_LENGTH = 255
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic                  eoi,
  input  cnls_pkg::char_class_t cls,
  output cnls_pkg::scan_res_t   res
);
  import cnls_pkg::*;

  localparam logic [7:0] LenCap = 8'((MAX_LENGTH < 255) ? MAX_LENGTH : 255);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ZERO, ST_INT, ST_BIN_START, ST_BIN, ST_HEX_START, ST_HEX,
    ST_FRAC, ST_EXP_START, ST_EXP_SIGN, ST_EXP, ST_SKIP
  } scan_st_t;

  typedef enum logic [2:0] {
    ACT_HOLD, ACT_ACCEPT, ACT_FAIL, ACT_FINISH, ACT_EXAMINE
  } act_t;

  scan_st_t   st_r, st_nxt;
  logic [7:0] cnt_r, cnt_nxt;

  act_t       act;
  scan_st_t   acc_st;
  logic [1:0] fin_kind;
  scan_st_t   ex_st;
  logic [7:0] ex_cnt;
  logic [7:0] inc_cnt;

  assign inc_cnt = (cnt_r < LenCap) ? cnt_r + 8'd1 : cnt_r;

  // where a character leaves the scanner when looked at as a fresh start
  always_comb begin
    priority if (cls.zero) begin
      ex_st  = ST_ZERO;
      ex_cnt = 8'd1;
    end else if (cls.digit) begin
      ex_st  = ST_INT;
      ex_cnt = 8'd1;
    end else begin
      ex_st  = cls.word ? ST_SKIP : ST_IDLE;
      ex_cnt = 8'd0;
    end
  end

  // per-state choice of action
  always_comb begin
    act      = ACT_EXAMINE;
    acc_st   = ST_IDLE;
    fin_kind = KIND_INT;
    unique case (st_r)
      ST_ZERO, ST_INT: begin
        priority if (st_r == ST_ZERO && cls.lc_b) begin
          act = ACT_ACCEPT; acc_st = ST_BIN_START;
        end else if (st_r == ST_ZERO && cls.lc_x) begin
          act = ACT_ACCEPT; acc_st = ST_HEX_START;
        end else if (cls.digit) begin
          act = ACT_ACCEPT; acc_st = ST_INT;
        end else if (cls.dot) begin
          act = ACT_ACCEPT; acc_st = ST_FRAC;
        end else if (cls.lc_e) begin
          act = ACT_ACCEPT; acc_st = ST_EXP_START;
        end else if (cls.alpha) begin
          act = ACT_FAIL;
        end else begin
          act = ACT_FINISH;
        end
      end
      ST_BIN_START: begin
        if (cls.bin) begin
          act = ACT_ACCEPT; acc_st = ST_BIN;
        end else begin
          act = ACT_FAIL;
        end
      end
      ST_BIN: begin
        priority if (cls.bin) begin
          act = ACT_ACCEPT; acc_st = ST_BIN;
        end else if (cls.digit || cls.alpha) begin
          act = ACT_FAIL;
        end else begin
          act = ACT_FINISH;
        end
      end
      ST_HEX_START: begin
        if (cls.hex) begin
          act = ACT_ACCEPT; acc_st = ST_HEX;
        end else begin
          act = ACT_FAIL;
        end
      end
      ST_HEX: begin
        priority if (cls.hex) begin
          act = ACT_ACCEPT; acc_st = ST_HEX;
        end else if (cls.alpha) begin
          act = ACT_FAIL;
        end else begin
          act = ACT_FINISH;
        end
      end
      ST_FRAC: begin
        fin_kind = KIND_FLOAT;
        priority if (cls.digit) begin
          act = ACT_ACCEPT; acc_st = ST_FRAC;
        end else if (cls.lc_e) begin
          act = ACT_ACCEPT; acc_st = ST_EXP_START;
        end else if (cls.alpha) begin
          act = ACT_FAIL;
        end else begin
          act = ACT_FINISH;
        end
      end
      ST_EXP_START: begin
        priority if (cls.digit) begin
          act = ACT_ACCEPT; acc_st = ST_EXP;
        end else if (cls.sign) begin
          act = ACT_ACCEPT; acc_st = ST_EXP_SIGN;
        end else begin
          act = ACT_FAIL;
        end
      end
      ST_EXP_SIGN: begin
        if (cls.digit) begin
          act = ACT_ACCEPT; acc_st = ST_EXP;
        end else begin
          act = ACT_FAIL;
        end
      end
      ST_EXP: begin
        fin_kind = KIND_FLOAT;
        priority if (cls.digit) begin
          act = ACT_ACCEPT; acc_st = ST_EXP;
        end else if (cls.alpha) begin
          act = ACT_FAIL;
        end else begin
          act = ACT_FINISH;
        end
      end
      ST_SKIP: begin
        act = cls.word ? ACT_HOLD : ACT_EXAMINE;
      end
      default: begin
        act = ACT_EXAMINE;
      end
    endcase
  end

  // apply the action, or close the literal on end of input
  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    res.vld    = 1'b0;
    res.kind   = KIND_INT;
    res.length = cnt_r;
    if (eoi) begin
      st_nxt  = ST_IDLE;
      cnt_nxt = 8'd0;
      unique case (st_r)
        ST_ZERO, ST_INT, ST_BIN, ST_HEX: begin
          res.vld  = 1'b1;
          res.kind = KIND_INT;
        end
        ST_FRAC, ST_EXP: begin
          res.vld  = 1'b1;
          res.kind = KIND_FLOAT;
        end
        ST_BIN_START, ST_HEX_START, ST_EXP_START, ST_EXP_SIGN: begin
          res.vld  = 1'b1;
          res.kind = KIND_ERR;
        end
        default: begin
          res.vld = 1'b0;
        end
      endcase
    end else begin
      unique case (act)
        ACT_ACCEPT: begin
          st_nxt  = acc_st;
          cnt_nxt = inc_cnt;
        end
        ACT_FAIL: begin
          // rest of the offending word is swallowed
          res.vld  = 1'b1;
          res.kind = KIND_ERR;
          st_nxt   = cls.word ? ST_SKIP : ST_IDLE;
          cnt_nxt  = 8'd0;
        end
        ACT_FINISH: begin
          res.vld  = 1'b1;
          res.kind = fin_kind;
          st_nxt   = ex_st;
          cnt_nxt  = ex_cnt;
        end
        ACT_EXAMINE: begin
          st_nxt  = ex_st;
          cnt_nxt = ex_cnt;
        end
        default: begin
          st_nxt  = st_r;
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= 8'd0;
    end else if (step_en) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/cnls_checker.sv */
// port level checks of the numeric literal scanner, bound to the top level
// depends on cnls_pkg and c_number_literal_scanner_unit_defines.svh
`timescale 1ns / 1ps
`include "c_number_literal_scanner_unit_defines.svh"

module cnls_checker #(
  parameter int unsigned MAX_LENGTH = 255
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser
);
  import cnls_pkg::*;

  localparam logic [7:0] LenCap = 8'((MAX_LENGTH < 255) ? MAX_LENGTH : 255);

  logic unused_in;
  assign unused_in = in_tvalid ^ in_tready ^ (^in_tdata) ^ in_tlast;

  // no result comes out of reset
  `CNLS_ASSERT_NEXT(a_reset_quiet, !rst_n, !out_tvalid)

  // a stalled result beat stays put
  `CNLS_ASSERT_RUN_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // a good literal has at least one digit, a float at least two characters
  `CNLS_ASSERT_RUN(a_len_min, out_tvalid && out_tuser != KIND_ERR, out_tdata != 8'd0 && (out_tuser != KIND_FLOAT || out_tdata >= 8'd2))

  // reported length saturates at the cap
  `CNLS_ASSERT_RUN(a_len_cap, out_tvalid, out_tdata <= LenCap)

endmodule

bind c_number_literal_scanner_unit cnls_checker #(
  .MAX_LENGTH (MAX_LENGTH)
) u_cnls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
